/* design/line_fold_at_last_blank_defines.svh */
// Assertion macros shared by the line folder.
`ifndef LINE_FOLD_AT_LAST_BLANK_DEFINES_SVH
`define LINE_FOLD_AT_LAST_BLANK_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/lfold_pkg.sv */
package lfold_pkg;

	localparam logic [7:0] CHAR_SPACE = 8'd32;
	localparam logic [7:0] CHAR_TAB = 8'd9;
	localparam logic [7:0] CHAR_NL = 8'd10;

	localparam logic [5:0] WIDTH_RESET = 6'd20;
	localparam logic [5:0] WIDTH_MIN = 6'd2;

	function automatic logic is_blank(input logic [7:0] c);
		return (c == CHAR_SPACE) || (c == CHAR_TAB);
	endfunction

endpackage

/* design/lfold_front.sv */
module lfold_front import lfold_pkg::*; #(
	parameter int MAX_WIDTH = 32,
	parameter int DEPTH = 64,
	parameter int AW = 6,
	parameter int CW = 6,
	parameter int PW = 5
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [5:0]    line_width,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic [7:0]    ch,
	input  logic          flush,
	input  logic          busy,
	output logic          job_push,
	output logic [AW-1:0] job_base,
	output logic [CW-1:0] job_count,
	output logic          job_nl,
	output logic          wr_en,
	output logic [AW-1:0] wr_addr,
	output logic [7:0]    wr_data
);

	logic [AW-1:0] base_q;
	logic [CW-1:0] fill_q;
	logic [PW-1:0] bpos_q;
	logic          seen_q;

	logic [5:0]    eff_w;
	logic          blank;
	logic          is_nl;
	logic [PW-1:0] bpos_n;
	logic          seen_n;
	logic [CW-1:0] nf;
	logic          brk;
	logic          job_req;
	logic          acc;
	logic [AW-1:0] base_d;
	logic [CW-1:0] fill_d;
	logic [PW-1:0] bpos_d;
	logic          seen_d;

	function automatic logic [AW-1:0] addr_add(input logic [AW-1:0] a, input logic [CW:0] x);
		logic [AW:0] s;
		s = {1'b0, a} + (AW+1)'(x);
		if (s >= (AW+1)'(DEPTH)) begin
			s = s - (AW+1)'(DEPTH);
		end
		return s[AW-1:0];
	endfunction

	always_comb begin
		if (line_width < WIDTH_MIN) begin
			eff_w = WIDTH_MIN;
		end else if ({1'b0, line_width} > 7'(MAX_WIDTH)) begin
			eff_w = 6'(MAX_WIDTH);
		end else begin
			eff_w = line_width;
		end
	end

	assign blank = is_blank(ch);
	assign is_nl = (ch == CHAR_NL);
	assign bpos_n = blank ? PW'(fill_q) : bpos_q;
	assign seen_n = seen_q | blank;
	assign nf = fill_q + CW'(1);
	assign brk = (7'(nf) >= 7'(eff_w));
	assign job_req = flush ? (fill_q != '0) : (is_nl || brk);
	assign in_stall = job_req && busy;
	assign acc = in_valid && !in_stall;
	assign job_push = acc && job_req;

	assign wr_en = acc && !flush && !is_nl;
	assign wr_addr = addr_add(base_q, {1'b0, fill_q});
	assign wr_data = ch;

	always_comb begin
		job_base = base_q;
		job_count = fill_q;
		job_nl = 1'b1;
		base_d = addr_add(base_q, {1'b0, fill_q});
		fill_d = '0;
		bpos_d = '0;
		seen_d = 1'b0;
		if (flush) begin
			job_nl = 1'b0;
		end else if (is_nl) begin
			job_nl = 1'b1;
		end else if (!brk) begin
			base_d = base_q;
			fill_d = nf;
			bpos_d = bpos_n;
			seen_d = seen_n;
		end else if (seen_n) begin
			job_count = CW'(bpos_n);
			base_d = addr_add(base_q, (CW+1)'(bpos_n) + (CW+1)'(1));
			fill_d = nf - CW'(bpos_n) - CW'(1);
		end else begin
			job_count = nf;
			base_d = addr_add(base_q, {1'b0, nf});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			fill_q <= '0;
			bpos_q <= '0;
			seen_q <= 1'b0;
		end else if (acc) begin
			base_q <= base_d;
			fill_q <= fill_d;
			bpos_q <= bpos_d;
			seen_q <= seen_d;
		end
	end

endmodule

/* design/lfold_back.sv */
module lfold_back import lfold_pkg::*; #(
	parameter int DEPTH = 64,
	parameter int AW = 6,
	parameter int CW = 6
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    wr_data,
	input  logic          job_valid,
	input  logic [AW-1:0] job_base,
	input  logic [CW-1:0] job_count,
	input  logic          job_nl,
	output logic          job_pop,
	output logic          busy,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [7:0]    out_char,
	output logic          last_of_run
);

	logic [7:0]    mem [DEPTH];

	logic          act_q;
	logic [AW-1:0] jbase_q;
	logic [CW-1:0] jcnt_q;
	logic          jnl_q;
	logic [CW-1:0] pos_q;

	logic [7:0]    rd_data_s1;
	logic          valid_s1;
	logic          nl_s1;
	logic          last_s1;

	logic          out_v_q;
	logic [7:0]    out_char_q;
	logic          last_q;

	logic          move;
	logic          issue;
	logic          at_nl;
	logic          is_last;
	logic [AW-1:0] rd_addr;

	function automatic logic [AW-1:0] addr_add(input logic [AW-1:0] a, input logic [CW-1:0] x);
		logic [AW:0] s;
		s = {1'b0, a} + (AW+1)'(x);
		if (s >= (AW+1)'(DEPTH)) begin
			s = s - (AW+1)'(DEPTH);
		end
		return s[AW-1:0];
	endfunction

	assign move = valid_s1 && (!out_v_q || !out_stall);
	assign issue = act_q && (!valid_s1 || move);
	assign at_nl = (pos_q == jcnt_q);
	assign is_last = at_nl || (!jnl_q && (pos_q == jcnt_q - CW'(1)));
	assign rd_addr = addr_add(jbase_q, pos_q);
	assign job_pop = job_valid && !act_q;
	assign busy = act_q;

	assign out_valid = out_v_q;
	assign out_char = out_char_q;
	assign last_of_run = last_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (issue) begin
			rd_data_s1 <= mem[rd_addr];
			nl_s1 <= at_nl;
			last_s1 <= is_last;
		end
		if (job_pop) begin
			jbase_q <= job_base;
			jcnt_q <= job_count;
			jnl_q <= job_nl;
		end
		if (move) begin
			out_char_q <= nl_s1 ? CHAR_NL : rd_data_s1;
			last_q <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
			pos_q <= '0;
			valid_s1 <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (job_pop) begin
				act_q <= 1'b1;
				pos_q <= '0;
			end else if (issue) begin
				if (is_last) begin
					act_q <= 1'b0;
				end else begin
					pos_q <= pos_q + CW'(1);
				end
			end
			if (issue) begin
				valid_s1 <= 1'b1;
			end else if (move) begin
				valid_s1 <= 1'b0;
			end
			if (move) begin
				out_v_q <= 1'b1;
			end else if (!out_stall) begin
				out_v_q <= 1'b0;
			end
		end
	end

endmodule

/* design/line_fold_at_last_blank.sv */
// Line folder. Characters enter one word at a time on the input channel (ch, flush),
// and folded text leaves one character per word on the output channel (out_char,
// last_of_run). A held line is broken when it reaches line_width columns, at its last
// space or tab, which becomes a newline; without a blank it breaks hard at the width.
// A newline input emits the held line and the newline, and a flush emits the held
// characters only. last_of_run marks the final word that one input causes.
// The register line_width is written through cfg_wr_en and cfg_wr_data; the user must
// write it only while idle, and the block does not enforce this. An input that causes
// no output is taken without a stall, also while earlier output is still being sent.
// An input that causes output waits until the previous output run has been read from
// the line memory; its run of N words then goes through the job queue, the back end's
// job registers, the read stage and the output register, and leaves at one word per
// cycle while the receiver does not stall. The memory's read port sets that rate.
// Reset clears the held line, the output and the queue, and sets line_width to 20.
// When the receiver stalls, the output word holds and the back end stops reading;
// the front end keeps taking characters that cause no output.
`include "line_fold_at_last_blank_defines.svh"

module line_fold_at_last_blank import lfold_pkg::*; #(
	parameter int MAX_WIDTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [5:0] cfg_wr_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] ch,
	input  logic       flush,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_char,
	output logic       last_of_run
);

	localparam int DEPTH = 2 * MAX_WIDTH;
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(MAX_WIDTH + 1);
	localparam int PW = $clog2(MAX_WIDTH);

	logic [5:0]    line_width_q;

	logic          q_v_q;
	logic [AW-1:0] q_base_q;
	logic [CW-1:0] q_cnt_q;
	logic          q_nl_q;

	logic          job_push;
	logic [AW-1:0] job_base;
	logic [CW-1:0] job_count;
	logic          job_nl;
	logic          job_pop;
	logic          back_busy;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [7:0]    wr_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q <= WIDTH_RESET;
		end else if (cfg_wr_en) begin
			line_width_q <= cfg_wr_data;
		end
	end

	lfold_front #(
		.MAX_WIDTH(MAX_WIDTH),
		.DEPTH(DEPTH),
		.AW(AW),
		.CW(CW),
		.PW(PW)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.line_width(line_width_q),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.ch(ch),
		.flush(flush),
		.busy(q_v_q || back_busy),
		.job_push(job_push),
		.job_base(job_base),
		.job_count(job_count),
		.job_nl(job_nl),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_v_q <= 1'b0;
		end else if (job_push) begin
			q_v_q <= 1'b1;
		end else if (job_pop) begin
			q_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (job_push) begin
			q_base_q <= job_base;
			q_cnt_q <= job_count;
			q_nl_q <= job_nl;
		end
	end

	lfold_back #(
		.DEPTH(DEPTH),
		.AW(AW),
		.CW(CW)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.job_valid(q_v_q),
		.job_base(q_base_q),
		.job_count(q_cnt_q),
		.job_nl(q_nl_q),
		.job_pop(job_pop),
		.busy(back_busy),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_char(out_char),
		.last_of_run(last_of_run)
	);

	`LF_ASSERT_NOW(a_no_queue_overwrite, clk, arst_n, job_push, !q_v_q && !back_busy, "job pushed while a run is pending")
	`LF_ASSERT_NOW(a_job_not_empty, clk, arst_n, job_push, (job_count != '0) || job_nl, "job pushed with no output")
	`LF_ASSERT_NEXT(a_pop_starts_run, clk, arst_n, job_pop, back_busy && !q_v_q, "popped job did not start a run")

endmodule
